### hw/rtl/sebs_pkg.sv
// Shared types and constants of the Sobel edge saturation boost block.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package sebs_pkg;

	// Payload widths
	localparam int PIX_W      = 8;   // grey and saturation bytes
	localparam int POS_W      = 11;  // emitted row and column indexes
	localparam int CFG_DATA_W = 12;  // geometry register width
	localparam int CFG_IDX_W  = 2;   // register index width

	// Gradient arithmetic
	localparam int GRAD_W  = 12;     // signed Sobel component
	localparam int ABS_W   = 11;     // |gx|, |gy| <= 1020
	localparam int MAG_W   = 22;     // gx^2 + gy^2 < 2^21, kept even for digit pairs
	localparam int ROOT_W  = 11;     // isqrt of a MAG_W value
	localparam int BOOST_W = 12;     // saturation plus root

	localparam logic [MAG_W-1:0]   BOOST_THRESH = MAG_W'(100);  // magnitude above 10
	localparam logic [BOOST_W-1:0] SAT_MAX      = BOOST_W'(255);

	// Geometry register reset values
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// One line buffer entry: two grey rows and the saturation row
	typedef struct packed {
		logic [PIX_W-1:0] grey_older;
		logic [PIX_W-1:0] grey_newer;
		logic [PIX_W-1:0] sat;
	} line_word_t;

endpackage

`default_nettype wire

### hw/rtl/sebs_pix_if.sv
// Input pixel channel: valid/ready with grey value and saturation byte.
// Depends on sebs_pkg for payload widths.
`default_nettype none

interface sebs_pix_if;
	logic                      valid;
	logic                      ready;
	logic [sebs_pkg::PIX_W-1:0] grey_value;
	logic [sebs_pkg::PIX_W-1:0] saturation_in;

	modport source (output valid, output grey_value, output saturation_in, input ready);
	modport sink   (input valid, input grey_value, input saturation_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/sebs_res_if.sv
// Result channel: valid/ready with pixel position, boosted saturation, frame end.
// Depends on sebs_pkg for payload widths.
`default_nettype none

interface sebs_res_if;
	logic                       valid;
	logic                       ready;
	logic [sebs_pkg::POS_W-1:0] pixel_row;
	logic [sebs_pkg::POS_W-1:0] pixel_column;
	logic [sebs_pkg::PIX_W-1:0] saturation_out;
	logic                       frame_last;

	modport source (output valid, output pixel_row, output pixel_column,
		output saturation_out, output frame_last, input ready);
	modport sink   (input valid, input pixel_row, input pixel_column,
		input saturation_out, input frame_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/sebs_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on sebs_pkg for index and data widths.
`default_nettype none

interface sebs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sebs_pkg::CFG_IDX_W-1:0]  index;
	logic [sebs_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/sebs_line_mem.sv
// Line buffer memory: one entry per column holding both grey rows and saturation.
// Depends on sebs_pkg for the entry type; one write and one registered read port.
`default_nettype none

module sebs_line_mem #(
	parameter int DEPTH = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
	output sebs_pkg::line_word_t             rd_data,
	input  wire logic                        wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  wire sebs_pkg::line_word_t        wr_data
);

	sebs_pkg::line_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sebs_isqrt.sv
// Iterative floor square root, one result bit (one operand bit pair) per cycle.
// Depends on sebs_pkg for operand and root widths.
`default_nettype none

module sebs_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sebs_pkg::MAG_W-1:0]   value,
	output logic                              done,
	output logic [sebs_pkg::ROOT_W-1:0]       root
);

	localparam int MW = sebs_pkg::MAG_W;

	logic [MW-1:0] rem_q;
	logic [MW-1:0] res_q;
	logic [MW-1:0] bit_q;
	logic          done_q;
	logic [MW:0]   trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= value;
				res_q <= '0;
				bit_q <= MW'(1) << (MW - 2);
			end else if (bit_q != '0) begin
				// accept the trial digit when the remainder covers it
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= rem_q - trial[MW-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				done_q <= (bit_q == MW'(1));
			end
		end
	end

	assign done = done_q;
	assign root = res_q[sebs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/sobel_edge_saturation_boost.sv
// Top level of the Sobel edge saturation boost: sequencer, window, output register.
// Depends on sebs_pkg, the three channel interfaces, sebs_line_mem and sebs_isqrt.
//
//   Channel  Dir   Handshake     Beat contents
//   cfg      in    valid/ready   index, data (geometry register write)
//   pixels   in    valid/ready   grey_value, saturation_in (raster order)
//   results  out   valid/ready   pixel_row, pixel_column, saturation_out, frame_last
//
// One pixel at a time through IDLE, READ and EMIT, which sends its results in turn;
// interior pixels add GRAD, SQR, SUM; boosted ones also wait in ROOT (11-step root).
// The line memory is read at accept and written back the next cycle; the next pixel
// comes later, so no forwarding is needed.
// Reset restores 640x480 and frame start; the line memory is not cleared.
// A stalled result holds in the output register while the next pixel may be taken.
`default_nettype none

module sobel_edge_saturation_boost #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input wire logic         clk,
	input wire logic         arst_n,
	sebs_cfg_if.sink         cfg,
	sebs_pix_if.sink         pixels,
	sebs_res_if.source       results
);

	localparam int CW     = $clog2(MAX_WIDTH);       // column counter and memory address
	localparam int RW     = $clog2(MAX_HEIGHT);      // row counter
	localparam int WW     = $clog2(MAX_WIDTH + 1);   // clamped width
	localparam int HW     = $clog2(MAX_HEIGHT + 1);  // clamped height
	localparam int CMPW_W = (WW > sebs_pkg::CFG_DATA_W) ? WW : sebs_pkg::CFG_DATA_W;
	localparam int CMPW_H = (HW > sebs_pkg::CFG_DATA_W) ? HW : sebs_pkg::CFG_DATA_W;
	localparam int RST_W  = (sebs_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
		: sebs_pkg::WIDTH_RESET;
	localparam int RST_H  = (sebs_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
		: sebs_pkg::HEIGHT_RESET;
	localparam int PW     = sebs_pkg::PIX_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_GRAD,
		S_SQR,
		S_SUM,
		S_ROOT,
		S_EMIT
	} state_t;

	state_t state_q;

	// Geometry, already clamped to 1..MAX
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;

	// Raster position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Pixel under work
	logic [PW-1:0] grey_q;
	logic [PW-1:0] sat_q;
	logic [CW-1:0] col_item_q;
	logic [RW-1:0] row_item_q;
	logic          col_last_q;
	logic          interior_q;
	logic          pend_a_q;
	logic          pend_b_q;
	logic          pend_c_q;
	logic [PW-1:0] old_sat_q;
	logic [PW-1:0] sat_a_q;
	logic [PW-1:0] sat_delay_q;

	// 3x3 window, row-major, column 2 newest
	logic [PW-1:0] win_q [9];

	// Gradient pipeline through the sequencer
	logic [sebs_pkg::ABS_W-1:0] ax_q;
	logic [sebs_pkg::ABS_W-1:0] ay_q;
	logic [sebs_pkg::MAG_W-1:0] sqx_q;
	logic [sebs_pkg::MAG_W-1:0] sqy_q;

	// Output register
	logic                       out_valid_q;
	logic [sebs_pkg::POS_W-1:0] out_row_q;
	logic [sebs_pkg::POS_W-1:0] out_col_q;
	logic [PW-1:0]              out_sat_q;
	logic                       out_last_q;

	// ---------------------------------------------------------------
	// Configuration clamp
	// ---------------------------------------------------------------
	logic [CMPW_W-1:0] cfg_w_ext;
	logic [CMPW_H-1:0] cfg_h_ext;
	logic [WW-1:0]     cfg_w_clamp;
	logic [HW-1:0]     cfg_h_clamp;
	logic              cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_comb begin
		cfg_w_ext = CMPW_W'(cfg.data);
		cfg_h_ext = CMPW_H'(cfg.data);
		if (cfg_w_ext == '0) begin
			cfg_w_clamp = WW'(1);
		end else if (cfg_w_ext > CMPW_W'(MAX_WIDTH)) begin
			cfg_w_clamp = WW'(MAX_WIDTH);
		end else begin
			cfg_w_clamp = WW'(cfg_w_ext);
		end
		if (cfg_h_ext == '0) begin
			cfg_h_clamp = HW'(1);
		end else if (cfg_h_ext > CMPW_H'(MAX_HEIGHT)) begin
			cfg_h_clamp = HW'(MAX_HEIGHT);
		end else begin
			cfg_h_clamp = HW'(cfg_h_ext);
		end
	end

	// ---------------------------------------------------------------
	// Position decode of the incoming pixel
	// ---------------------------------------------------------------
	logic pix_fire;
	logic col_last;
	logic row_last;

	assign pixels.ready = (state_q == S_IDLE);
	assign pix_fire     = pixels.valid && pixels.ready;
	assign col_last     = (WW'(col_q) == (width_q - WW'(1)));
	assign row_last     = (HW'(row_q) == (height_q - HW'(1)));

	// ---------------------------------------------------------------
	// Line memory: read on accept, write back the following cycle
	// ---------------------------------------------------------------
	sebs_pkg::line_word_t mem_rd;
	sebs_pkg::line_word_t mem_wr;

	always_comb begin
		mem_wr.grey_older = mem_rd.grey_newer;
		mem_wr.grey_newer = grey_q;
		mem_wr.sat        = sat_q;
	end

	sebs_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (pix_fire),
		.rd_addr (col_q),
		.rd_data (mem_rd),
		.wr_en   (state_q == S_READ),
		.wr_addr (col_item_q),
		.wr_data (mem_wr)
	);

	// ---------------------------------------------------------------
	// Sobel components from the updated window
	// ---------------------------------------------------------------
	logic        [sebs_pkg::GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [sebs_pkg::GRAD_W-1:0] gx, gy;
	logic        [sebs_pkg::GRAD_W-1:0] gx_abs, gy_abs;

	always_comb begin
		gx_pos = sebs_pkg::GRAD_W'(win_q[6]) + (sebs_pkg::GRAD_W'(win_q[7]) << 1)
			+ sebs_pkg::GRAD_W'(win_q[8]);
		gx_neg = sebs_pkg::GRAD_W'(win_q[0]) + (sebs_pkg::GRAD_W'(win_q[1]) << 1)
			+ sebs_pkg::GRAD_W'(win_q[2]);
		gy_pos = sebs_pkg::GRAD_W'(win_q[2]) + (sebs_pkg::GRAD_W'(win_q[5]) << 1)
			+ sebs_pkg::GRAD_W'(win_q[8]);
		gy_neg = sebs_pkg::GRAD_W'(win_q[0]) + (sebs_pkg::GRAD_W'(win_q[3]) << 1)
			+ sebs_pkg::GRAD_W'(win_q[6]);
		gx     = $signed(gx_pos - gx_neg);
		gy     = $signed(gy_pos - gy_neg);
		gx_abs = gx[sebs_pkg::GRAD_W-1] ? $unsigned(-gx) : $unsigned(gx);
		gy_abs = gy[sebs_pkg::GRAD_W-1] ? $unsigned(-gy) : $unsigned(gy);
	end

	// ---------------------------------------------------------------
	// Magnitude and square root
	// ---------------------------------------------------------------
	logic [sebs_pkg::MAG_W-1:0]  mag;
	logic                        sq_start;
	logic                        sq_done;
	logic [sebs_pkg::ROOT_W-1:0] sq_root;
	logic [sebs_pkg::BOOST_W-1:0] boost_sum;

	assign mag       = sqx_q + sqy_q;
	assign sq_start  = (state_q == S_SUM) && (mag > sebs_pkg::BOOST_THRESH);
	assign boost_sum = sebs_pkg::BOOST_W'(sq_root) + sebs_pkg::BOOST_W'(sat_a_q);

	sebs_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (mag),
		.done   (sq_done),
		.root   (sq_root)
	);

	// ---------------------------------------------------------------
	// Result selection: up-left neighbor, row end of the row above, last-row passthrough
	// ---------------------------------------------------------------
	logic          out_free;
	logic          out_load;
	logic [RW-1:0] sel_row;
	logic [CW-1:0] sel_col;
	logic [31:0]   sel_row_ext;
	logic [31:0]   sel_col_ext;

	assign out_free = !out_valid_q || results.ready;
	assign out_load = (state_q == S_EMIT) && out_free && (pend_a_q || pend_b_q || pend_c_q);

	always_comb begin
		if (pend_a_q) begin
			sel_row = row_item_q - RW'(1);
			sel_col = col_item_q - CW'(1);
		end else if (pend_b_q) begin
			sel_row = row_item_q - RW'(1);
			sel_col = col_item_q;
		end else begin
			sel_row = row_item_q;
			sel_col = col_item_q;
		end
		sel_row_ext = 32'(sel_row);
		sel_col_ext = 32'(sel_col);
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WW'(RST_W);
			height_q    <= HW'(RST_H);
			col_q       <= '0;
			row_q       <= '0;
			grey_q      <= '0;
			sat_q       <= '0;
			col_item_q  <= '0;
			row_item_q  <= '0;
			col_last_q  <= 1'b0;
			interior_q  <= 1'b0;
			pend_a_q    <= 1'b0;
			pend_b_q    <= 1'b0;
			pend_c_q    <= 1'b0;
			old_sat_q   <= '0;
			sat_a_q     <= '0;
			sat_delay_q <= '0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			ax_q        <= '0;
			ay_q        <= '0;
			sqx_q       <= '0;
			sqy_q       <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_sat_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the result once taken unless a new one loads below
			if (results.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			// any geometry write restarts the frame
			if (cfg_fire) begin
				if (cfg.index == sebs_pkg::REG_IMAGE_WIDTH) begin
					width_q <= cfg_w_clamp;
					col_q   <= '0;
					row_q   <= '0;
				end else if (cfg.index == sebs_pkg::REG_IMAGE_HEIGHT) begin
					height_q <= cfg_h_clamp;
					col_q    <= '0;
					row_q    <= '0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (pix_fire) begin
						grey_q     <= pixels.grey_value;
						sat_q      <= pixels.saturation_in;
						col_item_q <= col_q;
						row_item_q <= row_q;
						col_last_q <= col_last;
						interior_q <= (row_q > RW'(1)) && (col_q > CW'(1));
						pend_a_q   <= (row_q != '0) && (col_q != '0);
						pend_b_q   <= (row_q != '0) && col_last;
						pend_c_q   <= row_last;
						// advance the raster position
						if (col_last) begin
							col_q <= '0;
							row_q <= row_last ? '0 : row_q + RW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// shift the window and insert the new column
					for (int k = 0; k < 3; k++) begin
						win_q[k*3 + 0] <= win_q[k*3 + 1];
						win_q[k*3 + 1] <= win_q[k*3 + 2];
					end
					win_q[2]    <= mem_rd.grey_older;
					win_q[5]    <= mem_rd.grey_newer;
					win_q[8]    <= grey_q;
					old_sat_q   <= mem_rd.sat;
					sat_a_q     <= sat_delay_q;
					sat_delay_q <= mem_rd.sat;
					state_q     <= (pend_a_q && interior_q) ? S_GRAD : S_EMIT;
				end
				S_GRAD: begin
					ax_q    <= gx_abs[sebs_pkg::ABS_W-1:0];
					ay_q    <= gy_abs[sebs_pkg::ABS_W-1:0];
					state_q <= S_SQR;
				end
				S_SQR: begin
					sqx_q   <= sebs_pkg::MAG_W'(ax_q) * sebs_pkg::MAG_W'(ax_q);
					sqy_q   <= sebs_pkg::MAG_W'(ay_q) * sebs_pkg::MAG_W'(ay_q);
					state_q <= S_SUM;
				end
				S_SUM: begin
					// weak edges keep the delayed saturation
					state_q <= sq_start ? S_ROOT : S_EMIT;
				end
				S_ROOT: begin
					if (sq_done) begin
						sat_a_q <= (boost_sum > sebs_pkg::SAT_MAX) ? PW'(sebs_pkg::SAT_MAX)
							: boost_sum[PW-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!(pend_a_q || pend_b_q || pend_c_q)) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q   <= sel_row_ext[sebs_pkg::POS_W-1:0];
						out_col_q   <= sel_col_ext[sebs_pkg::POS_W-1:0];
						if (pend_a_q) begin
							out_sat_q  <= sat_a_q;
							out_last_q <= 1'b0;
							pend_a_q   <= 1'b0;
							if (!(pend_b_q || pend_c_q)) begin
								state_q <= S_IDLE;
							end
						end else if (pend_b_q) begin
							out_sat_q  <= old_sat_q;
							out_last_q <= 1'b0;
							pend_b_q   <= 1'b0;
							if (!pend_c_q) begin
								state_q <= S_IDLE;
							end
						end else begin
							out_sat_q  <= sat_q;
							out_last_q <= col_last_q;
							pend_c_q   <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid          = out_valid_q;
	assign results.pixel_row      = out_row_q;
	assign results.pixel_column   = out_col_q;
	assign results.saturation_out = out_sat_q;
	assign results.frame_last     = out_last_q;

`ifndef SYNTHESIS
	// an accepted pixel always moves into the memory read cycle
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		pix_fire |=> (state_q == S_READ))
		else $error("accepted pixel did not enter the read cycle");

	// the root unit only finishes while the sequencer waits on it
	a_root_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_ROOT))
		else $error("square root finished outside its wait state");

	// a result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> $stable(out_sat_q) && $stable(out_col_q)
			&& out_valid_q)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### tb/sobel_edge_saturation_boost_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_saturation_boost: streams raster pixels,
// predicts emitted pixels (Sobel/isqrt model or table), compares beat by beat.
// Depends on sebs_pkg, the three channel interfaces and the block's RTL.

module sobel_edge_saturation_boost_tb;

	localparam int MAX_W         = 2048;
	localparam int MAX_H         = 2048;
	localparam int RANDOM_ITEMS  = 340;
	// Leave margin for the longest pixel to finish before touching registers.
	localparam int SETTLE_CYCLES = 24;
	localparam int LIMIT_CYCLES  = 3_000_000;

	localparam int IDX_W  = sebs_pkg::CFG_IDX_W;
	localparam int DATA_W = sebs_pkg::CFG_DATA_W;
	localparam int PX_W   = sebs_pkg::PIX_W;
	localparam int LOC_W  = sebs_pkg::POS_W;

	// Index 3 maps to no register: a write there must not restart the frame.
	localparam logic [IDX_W-1:0] REG_RESERVED = IDX_W'(3);

	// One emitted pixel as it appears on the result channel.
	typedef struct packed {
		logic [LOC_W-1:0] row;
		logic [LOC_W-1:0] column;
		logic [PX_W-1:0]  saturation;
		logic             last;
	} sat_pixel_t;

	typedef enum logic [1:0] {
		STEP_WRITE,   // register write, block idle
		STEP_PIXEL,   // pixel beat, result from the local model
		STEP_KNOWN    // pixel beat with exactly one result written in the table
	} step_kind_t;

	typedef enum logic [1:0] {
		PAT_NOISE,
		PAT_FLAT,
		PAT_EDGE,
		PAT_RAMP
	} pattern_t;

	typedef struct packed {
		step_kind_t        kind;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
		logic [PX_W-1:0]   grey;
		logic [PX_W-1:0]   sat;
		sat_pixel_t        known;
	} step_t;

	function automatic step_t write_step(logic [IDX_W-1:0] idx,
			logic [DATA_W-1:0] value);
		step_t st;
		st = '0;
		st.kind  = STEP_WRITE;
		st.index = idx;
		st.data  = value;
		return st;
	endfunction

	function automatic step_t pixel_step(logic [PX_W-1:0] g, logic [PX_W-1:0] s);
		step_t st;
		st = '0;
		st.kind = STEP_PIXEL;
		st.grey = g;
		st.sat  = s;
		return st;
	endfunction

	function automatic step_t known_step(logic [PX_W-1:0] g, logic [PX_W-1:0] s,
			int r, int c, logic [PX_W-1:0] s_out, logic last);
		step_t st;
		st = pixel_step(g, s);
		st.kind  = STEP_KNOWN;
		st.known = '{LOC_W'(r), LOC_W'(c), s_out, last};
		return st;
	endfunction

	// Directed opening: reset geometry, clamped geometries, the unused register,
	// and two 3x3 frames around the boost threshold.
	localparam int NUM_DIRECTED = 31;
	localparam step_t DIRECTED [NUM_DIRECTED] = '{
		// 640x480 after reset: first row yields nothing
		pixel_step(8'h5A, 8'hA5),
		pixel_step(8'h00, 8'h00),
		// zero geometry is taken as 1x1: every beat is its own last pixel
		write_step(sebs_pkg::REG_IMAGE_WIDTH, 12'd0),
		write_step(sebs_pkg::REG_IMAGE_HEIGHT, 12'd0),
		known_step(8'h00, 8'h00, 0, 0, 8'h00, 1'b1),
		known_step(8'hFF, 8'hFF, 0, 0, 8'hFF, 1'b1),
		// oversize width clamps to the maximum; single row passes straight through
		write_step(sebs_pkg::REG_IMAGE_WIDTH, 12'd4095),
		write_step(sebs_pkg::REG_IMAGE_HEIGHT, 12'd1),
		known_step(8'h80, 8'h7F, 0, 0, 8'h7F, 1'b0),
		known_step(8'h01, 8'h80, 0, 1, 8'h80, 1'b0),
		// 3x3 frame: magnitude exactly 10 at the center, so no boost
		write_step(sebs_pkg::REG_IMAGE_WIDTH, 12'd3),
		write_step(sebs_pkg::REG_IMAGE_HEIGHT, 12'd3),
		pixel_step(8'd0, 8'd10),
		pixel_step(8'd0, 8'd20),
		pixel_step(8'd0, 8'd30),
		pixel_step(8'd0, 8'd40),
		// write to no register in mid frame: the frame must carry on
		write_step(REG_RESERVED, 12'hFFF),
		pixel_step(8'd0, 8'd200),
		pixel_step(8'd0, 8'd60),
		pixel_step(8'd0, 8'd70),
		pixel_step(8'd5, 8'd80),
		pixel_step(8'd0, 8'd90),
		// next frame wraps in: magnitude 12 on saturation 250 clips at 255
		pixel_step(8'd0, 8'd1),
		pixel_step(8'd0, 8'd2),
		pixel_step(8'd0, 8'd3),
		pixel_step(8'd0, 8'd4),
		pixel_step(8'd0, 8'd250),
		pixel_step(8'd0, 8'd6),
		pixel_step(8'd0, 8'd7),
		pixel_step(8'd6, 8'd8),
		pixel_step(8'd0, 8'd9)
	};

	logic clk;
	logic arst_n;

	sebs_cfg_if cfg ();
	sebs_pix_if pixels ();
	sebs_res_if results ();

	sobel_edge_saturation_boost #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixels (pixels),
		.results(results)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Local model of the block: line buffers, window, counters, geometry.
	// ---------------------------------------------------------------------
	logic [PX_W-1:0]   grey_older_line [MAX_W] = '{default: '0};
	logic [PX_W-1:0]   grey_newer_line [MAX_W] = '{default: '0};
	logic [PX_W-1:0]   sat_line        [MAX_W] = '{default: '0};
	logic [PX_W-1:0]   sobel_win       [9]     = '{default: '0};
	logic [PX_W-1:0]   sat_lag    = '0;
	int unsigned       row_pos    = 0;
	int unsigned       col_pos    = 0;
	logic [DATA_W-1:0] width_reg  = DATA_W'(sebs_pkg::WIDTH_RESET);
	logic [DATA_W-1:0] height_reg = DATA_W'(sebs_pkg::HEIGHT_RESET);

	// Emitted pixels still owed by the block, oldest first.
	sat_pixel_t  pixels_due [$];
	int unsigned mismatches  = 0;
	int unsigned cycles      = 0;
	bit          calm_tail   = 1'b0;  // no idling on either side
	bit          feed_bursts = 1'b1;  // sender inserts gaps in this phase

	// Zero means 1, anything past the buffer size means the buffer size.
	function automatic int unsigned usable_dim(logic [DATA_W-1:0] v, int unsigned cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : int'(v);
	endfunction

	// Floor square root, one result bit at a time from the top.
	function automatic int unsigned floor_root(int unsigned m);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = sebs_pkg::ROOT_W - 1; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= m)
				root = trial;
		end
		return root;
	endfunction

	// Take one pixel into the model; return the pixels it releases, in order.
	function automatic int sobel_boost_step(logic [PX_W-1:0] g, logic [PX_W-1:0] s,
			output sat_pixel_t outs [3]);
		int unsigned     w, h, r, c, boosted, mag;
		logic [PX_W-1:0] top_old, mid_old, sat_old, sat_prev;
		int              gx, gy, n;
		w = usable_dim(width_reg, MAX_W);
		h = usable_dim(height_reg, MAX_H);
		r = (row_pos >= h) ? h - 1 : row_pos;
		c = (col_pos >= w) ? w - 1 : col_pos;
		n = 0;
		outs = '{default: '0};

		top_old  = grey_older_line[c];
		mid_old  = grey_newer_line[c];
		sat_old  = sat_line[c];
		sat_prev = sat_lag;

		// shift the window one column left, load the new column on the right
		for (int k = 0; k < 3; k++) begin
			sobel_win[k * 3]     = sobel_win[k * 3 + 1];
			sobel_win[k * 3 + 1] = sobel_win[k * 3 + 2];
		end
		sobel_win[2] = top_old;
		sobel_win[5] = mid_old;
		sobel_win[8] = g;

		grey_older_line[c] = mid_old;
		grey_newer_line[c] = g;
		sat_line[c]        = s;
		sat_lag            = sat_old;

		// pixel one row up and one column back
		if (r >= 1 && c >= 1) begin
			boosted = sat_prev;
			if (r >= 2 && c >= 2 && r - 1 <= h - 2 && c - 1 <= w - 2) begin
				gx = -int'(sobel_win[0]) - 2 * int'(sobel_win[1]) - int'(sobel_win[2])
					+ int'(sobel_win[6]) + 2 * int'(sobel_win[7]) + int'(sobel_win[8]);
				gy = -int'(sobel_win[0]) - 2 * int'(sobel_win[3]) - int'(sobel_win[6])
					+ int'(sobel_win[2]) + 2 * int'(sobel_win[5]) + int'(sobel_win[8]);
				mag = gx * gx + gy * gy;
				if (mag > sebs_pkg::BOOST_THRESH) begin
					boosted += floor_root(mag);
					if (boosted > sebs_pkg::SAT_MAX)
						boosted = sebs_pkg::SAT_MAX;
				end
			end
			outs[n] = '{LOC_W'(r - 1), LOC_W'(c - 1), PX_W'(boosted), 1'b0};
			n++;
		end
		// right border of the row above, flushed at the row end
		if (r >= 1 && c == w - 1) begin
			outs[n] = '{LOC_W'(r - 1), LOC_W'(c), sat_old, 1'b0};
			n++;
		end
		// bottom row leaves as it arrives
		if (r == h - 1) begin
			outs[n] = '{LOC_W'(r), LOC_W'(c), s, (c == w - 1)};
			n++;
		end

		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
		return n;
	endfunction

	// ---------------------------------------------------------------------
	// Drivers. Valid stays high between back-to-back beats; it is lowered
	// only at the step that starts a gap, so no step sees two assignments.
	// ---------------------------------------------------------------------

	// Drive one register write and hold until accepted; the caller drops valid.
	task automatic write_reg(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		// any real register write restarts the frame
		if (idx == sebs_pkg::REG_IMAGE_WIDTH) begin
			width_reg = value;
			row_pos   = 0;
			col_pos   = 0;
		end else if (idx == sebs_pkg::REG_IMAGE_HEIGHT) begin
			height_reg = value;
			row_pos    = 0;
			col_pos    = 0;
		end
	endtask

	// Drive one pixel beat, then log what it must release.
	task automatic feed_pixel(input logic [PX_W-1:0] g, input logic [PX_W-1:0] s,
			input bit known, input sat_pixel_t known_px);
		sat_pixel_t outs [3];
		int         n;
		if (!calm_tail && feed_bursts && $urandom_range(0, 3) == 0) begin
			pixels.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		pixels.valid         <= 1'b1;
		pixels.grey_value    <= g;
		pixels.saturation_in <= s;
		do @(posedge clk); while (!pixels.ready);
		n = sobel_boost_step(g, s, outs);
		if (known)
			pixels_due.push_back(known_px);
		else
			for (int k = 0; k < n; k++)
				pixels_due.push_back(outs[k]);
	endtask

	// Hold the sender until every owed pixel is out, then let a silent pixel finish.
	task automatic settle_block();
		pixels.valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly typical sizes, sometimes tiny, zero, wider or far past the buffer.
	function automatic logic [DATA_W-1:0] pick_dim(int unsigned typical_hi);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return DATA_W'($urandom_range(MAX_W + 1, 4095));
			2, 3:    return DATA_W'($urandom_range(1, 2));
			4, 5:    return DATA_W'($urandom_range(typical_hi + 1, typical_hi * 3));
			default: return DATA_W'($urandom_range(3, typical_hi));
		endcase
	endfunction

	// Set the geometry and stream one run of pixels with the given texture.
	task automatic run_phase(input logic [DATA_W-1:0] w_set,
			input logic [DATA_W-1:0] h_set, input int unsigned count,
			input pattern_t pattern);
		int unsigned     ew, col;
		logic [PX_W-1:0] g, s, flat_base, ramp_step;
		int unsigned     split;
		ew        = usable_dim(w_set, MAX_W);
		flat_base = PX_W'($urandom);
		ramp_step = PX_W'($urandom_range(1, 40));
		split     = $urandom_range(0, ew);

		settle_block();
		write_reg(sebs_pkg::REG_IMAGE_WIDTH, w_set);
		write_reg(sebs_pkg::REG_IMAGE_HEIGHT, h_set);
		cfg.valid <= 1'b0;

		for (int unsigned i = 0; i < count; i++) begin
			col = i % ew;
			case (pattern)
				PAT_FLAT: g = flat_base + PX_W'($urandom_range(0, 3));
				PAT_EDGE: g = (col >= split) ? 8'hFF - PX_W'($urandom_range(0, 2))
					: PX_W'($urandom_range(0, 2));
				PAT_RAMP: g = PX_W'(col) * ramp_step + PX_W'($urandom_range(0, 1));
				default:  g = PX_W'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0:       s = 8'hFF;
				1:       s = 8'h00;
				2:       s = PX_W'($urandom_range(230, 255));
				default: s = PX_W'($urandom);
			endcase
			// now and then drain the block in mid frame
			if (!calm_tail && $urandom_range(0, 39) == 0)
				settle_block();
			feed_pixel(g, s, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------------
	// Result side: ready in random bursts, compare every accepted beat.
	// ---------------------------------------------------------------------
	initial begin : result_sink
		int unsigned burst;
		bit          hold_low;
		burst = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm_tail) begin
				results.ready <= 1'b1;
			end else if (burst == 0) begin
				hold_low = ($urandom_range(0, 2) == 0);
				burst    = hold_low ? $urandom_range(1, 11) : $urandom_range(1, 30);
				results.ready <= !hold_low;
				burst--;
			end else begin
				burst--;
			end
		end
	end

	always @(posedge clk) begin
		sat_pixel_t want;
		if (results.valid && results.ready) begin
			if (pixels_due.size() == 0) begin
				$error("unexpected pixel at row %0d column %0d",
					results.pixel_row, results.pixel_column);
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				if (results.pixel_row !== want.row) begin
					$error("pixel_row: expected %0d, got %0d", want.row, results.pixel_row);
					mismatches++;
				end
				if (results.pixel_column !== want.column) begin
					$error("pixel_column: expected %0d, got %0d",
						want.column, results.pixel_column);
					mismatches++;
				end
				if (results.saturation_out !== want.saturation) begin
					$error("saturation_out: expected %0d, got %0d",
						want.saturation, results.saturation_out);
					mismatches++;
				end
				if (results.frame_last !== want.last) begin
					$error("frame_last: expected %0d, got %0d", want.last, results.frame_last);
					mismatches++;
				end
			end
		end
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus sequence.
	// ---------------------------------------------------------------------
	initial begin : stimulus
		logic [DATA_W-1:0] w_set, h_set;
		int unsigned       frame, count, fed;

		arst_n               = 1'b0;
		pixels.valid         <= 1'b0;
		pixels.grey_value    <= '0;
		pixels.saturation_in <= '0;
		cfg.valid            <= 1'b0;
		cfg.index            <= sebs_pkg::REG_IMAGE_WIDTH;
		cfg.data             <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; consecutive writes share one valid stretch.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED[i].kind == STEP_WRITE) begin
				if (i == 0 || DIRECTED[i - 1].kind != STEP_WRITE)
					settle_block();
				write_reg(DIRECTED[i].index, DIRECTED[i].data);
				if (i == NUM_DIRECTED - 1 || DIRECTED[i + 1].kind != STEP_WRITE)
					cfg.valid <= 1'b0;
			end else begin
				feed_pixel(DIRECTED[i].grey, DIRECTED[i].sat,
					DIRECTED[i].kind == STEP_KNOWN, DIRECTED[i].known);
			end
		end

		// Random geometries, mostly whole frames with textured content.
		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			w_set = pick_dim(12);
			h_set = pick_dim(8);
			frame = usable_dim(w_set, MAX_W) * usable_dim(h_set, MAX_H);
			if (frame <= 100)
				count = frame * $urandom_range(1, 2)
					+ (($urandom_range(0, 2) == 0) ? $urandom_range(1, frame) : 0);
			else
				count = $urandom_range(10, 90);
			feed_bursts = ($urandom_range(0, 3) != 0);
			run_phase(w_set, h_set, count, pattern_t'($urandom_range(0, 3)));
			fed += count;
		end

		// Closing stretch at full rate on both sides.
		calm_tail = 1'b1;
		run_phase(12'd5, 12'd4, 40, pattern_t'($urandom_range(0, 3)));
		settle_block();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/sebs_pkg.sv
hw/rtl/sebs_pix_if.sv
hw/rtl/sebs_res_if.sv
hw/rtl/sebs_cfg_if.sv
hw/rtl/sebs_line_mem.sv
hw/rtl/sebs_isqrt.sv
hw/rtl/sobel_edge_saturation_boost.sv
tb/sobel_edge_saturation_boost_tb.sv
